### design/tccw_pkg.sv
// Shared types, constants and helpers of the text console character writer.
package tccw_pkg;

   localparam int OP_W       = 2;
   localparam int CH_W       = 8;
   localparam int IDX_W      = 11;
   localparam int COLOR_W    = 8;
   localparam int CELL_W     = CH_W + COLOR_W;
   localparam int ROW_PORT_W = 5;
   localparam int COL_PORT_W = 7;
   localparam int TAB_CNT_W  = 3;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [CH_W-1:0] CH_SPACE      = 8'h20;
   localparam logic [CH_W-1:0] CH_NEWLINE    = 8'h0A;
   localparam logic [CH_W-1:0] CH_TAB        = 8'h09;
   localparam logic [CH_W-1:0] CH_LAST_PRINT = 8'h7E;

   localparam logic [TAB_CNT_W-1:0] TAB_WIDTH   = 3'd4;
   localparam logic [COLOR_W-1:0]   COLOR_RESET = 8'h0F;

   // Commands from the controller to the datapath in the current cycle.
   typedef struct packed {
      logic accept;
      logic put;
      logic put_space;
      logic newline;
      logic home;
      logic rd;
      logic sweep_start;
      logic sweep_clear;
      logic sweep_scroll;
      logic tab_load;
      logic tab_dec;
      logic rsp;
   } tccw_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic row_last;
      logic col_last;
      logic tab_last;
      logic clear_done;
      logic scroll_done;
   } tccw_status_type;

   function automatic logic is_printable(logic [CH_W-1:0] c);
      return c inside {[CH_SPACE:CH_LAST_PRINT]};
   endfunction

endpackage

### design/tccw_ctrl.sv
// Controller state machine that sequences puts, tabs, scrolls and clears.
module tccw_ctrl import tccw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [OP_W-1:0]  req_op,
   input  logic [CH_W-1:0]  req_ch,
   input  tccw_status_type  status,
   output logic             busy,
   output tccw_cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_RUN    = 4'b0001,
      ST_TAB    = 4'b0010,
      ST_SCROLL = 4'b0100,
      ST_CLEAR  = 4'b1000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          pend_ff, pend_in;
   logic          ret_tab_ff, ret_tab_in;
   logic          accept;
   logic          wrap_scroll;

   assign busy        = (state_ff != ST_RUN);
   assign accept      = start && !busy;
   assign wrap_scroll = status.col_last && status.row_last;

   always_comb begin
      state_in   = state_ff;
      pend_in    = pend_ff;
      ret_tab_in = ret_tab_ff;
      cmd        = '0;
      case (state_ff)
         ST_RUN: begin
            if (accept) begin
               cmd.accept = 1'b1;
               case (req_op)
                  OP_PUT: begin
                     if (is_printable(req_ch)) begin
                        cmd.put = 1'b1;
                        if (wrap_scroll) begin
                           cmd.sweep_start = 1'b1;
                           ret_tab_in      = 1'b0;
                           state_in        = ST_SCROLL;
                        end else begin
                           cmd.rsp = 1'b1;
                        end
                     end else if (req_ch == CH_NEWLINE) begin
                        cmd.newline = 1'b1;
                        if (status.row_last) begin
                           cmd.sweep_start = 1'b1;
                           ret_tab_in      = 1'b0;
                           state_in        = ST_SCROLL;
                        end else begin
                           cmd.rsp = 1'b1;
                        end
                     end else if (req_ch == CH_TAB) begin
                        cmd.tab_load = 1'b1;
                        state_in     = ST_TAB;
                     end else begin
                        cmd.rsp = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.home        = 1'b1;
                     cmd.sweep_start = 1'b1;
                     pend_in         = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  OP_READ: begin
                     cmd.rd  = 1'b1;
                     cmd.rsp = 1'b1;
                  end
                  default: begin
                     cmd.rsp = 1'b1;
                  end
               endcase
            end
         end
         ST_TAB: begin
            cmd.put       = 1'b1;
            cmd.put_space = 1'b1;
            cmd.tab_dec   = 1'b1;
            if (wrap_scroll) begin
               cmd.sweep_start = 1'b1;
               ret_tab_in      = !status.tab_last;
               state_in        = ST_SCROLL;
            end else if (status.tab_last) begin
               cmd.rsp  = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_SCROLL: begin
            cmd.sweep_scroll = 1'b1;
            if (status.scroll_done) begin
               if (ret_tab_ff) begin
                  state_in = ST_TAB;
               end else begin
                  cmd.rsp  = 1'b1;
                  state_in = ST_RUN;
               end
            end
         end
         ST_CLEAR: begin
            cmd.sweep_clear = 1'b1;
            if (status.clear_done) begin
               // The clearing pass after reset answers no transaction.
               cmd.rsp  = pend_ff;
               pend_in  = 1'b0;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         pend_ff    <= 1'b0;
         ret_tab_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         ret_tab_ff <= ret_tab_in;
      end
   end

endmodule

### design/tccw_datapath.sv
// Datapath: cell store, cursor, sweep pointer, color registers and result registers.
module tccw_datapath import tccw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tccw_cmd_type          cmd,
   input  logic [CH_W-1:0]       req_ch,
   input  logic [IDX_W-1:0]      req_cell_index,
   input  logic                  csr_valid,
   input  logic [COLOR_W-1:0]    csr_text_color,
   output tccw_status_type       status,
   output logic                  rsp_valid,
   output logic [CELL_W-1:0]     rsp_cell_word,
   output logic [ROW_PORT_W-1:0] rsp_cursor_row,
   output logic [COL_PORT_W-1:0] rsp_cursor_col
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int PTR_W      = $clog2(CELL_COUNT + 1);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COL_W      = $clog2(COLUMNS);

   logic [CELL_W-1:0] mem [CELL_COUNT];

   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [TAB_CNT_W-1:0] tab_cnt_ff, tab_cnt_in;
   logic [COLOR_W-1:0]   text_color_ff, text_color_in;
   logic [COLOR_W-1:0]   blank_color_ff, blank_color_in;
   logic [CELL_W-1:0]    rd_data_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_read_ff;

   logic [COLOR_W-1:0] cur_color;
   logic [CH_W-1:0]    put_ch;
   logic [ADDR_W-1:0]  cursor_addr;
   logic               idx_in_range;
   logic               scroll_rd_ok;
   logic               copy_ok;
   logic               row_last;
   logic               col_last;
   logic               we;
   logic [ADDR_W-1:0]  waddr;
   logic [CELL_W-1:0]  wdata;
   logic               re;
   logic [ADDR_W-1:0]  raddr;

   assign row_last     = (row_ff == ROW_W'(ROWS - 1));
   assign col_last     = (col_ff == COL_W'(COLUMNS - 1));
   // Sweeps use the color captured when the transaction was accepted.
   assign cur_color    = cmd.accept ? text_color_ff : blank_color_ff;
   assign put_ch       = cmd.put_space ? CH_SPACE : req_ch;
   assign cursor_addr  = ADDR_W'(row_ff * COLUMNS) + ADDR_W'(col_ff);
   assign idx_in_range = (32'(req_cell_index) < CELL_COUNT);
   assign scroll_rd_ok = (ptr_ff < PTR_W'(COPY_COUNT));
   assign copy_ok      = (ptr_ff <= PTR_W'(COPY_COUNT));

   // The scroll reads one row ahead and writes the word read in the previous cycle.
   always_comb begin
      we    = 1'b0;
      waddr = '0;
      wdata = '0;
      if (cmd.put) begin
         we    = 1'b1;
         waddr = cursor_addr;
         wdata = {cur_color, put_ch};
      end else if (cmd.sweep_clear) begin
         we    = 1'b1;
         waddr = ADDR_W'(ptr_ff);
         wdata = {cur_color, CH_SPACE};
      end else if (cmd.sweep_scroll && (ptr_ff != '0)) begin
         we    = 1'b1;
         waddr = ADDR_W'(ptr_ff - PTR_W'(1));
         wdata = copy_ok ? rd_data_ff : {cur_color, CH_SPACE};
      end
   end

   always_comb begin
      re    = cmd.rd || cmd.sweep_scroll;
      raddr = '0;
      if (cmd.rd) begin
         raddr = idx_in_range ? ADDR_W'(req_cell_index) : '0;
      end else if (scroll_rd_ok) begin
         raddr = ADDR_W'(ptr_ff + PTR_W'(COLUMNS));
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.home) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.newline || (cmd.put && col_last)) begin
         col_in = '0;
         if (!row_last) begin
            row_in = row_ff + ROW_W'(1);
         end
      end else if (cmd.put) begin
         col_in = col_ff + COL_W'(1);
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.sweep_start) begin
         ptr_in = '0;
      end else if (cmd.sweep_clear || cmd.sweep_scroll) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end
      tab_cnt_in = tab_cnt_ff;
      if (cmd.tab_load) begin
         tab_cnt_in = TAB_WIDTH;
      end else if (cmd.tab_dec) begin
         tab_cnt_in = tab_cnt_ff - TAB_CNT_W'(1);
      end
      text_color_in  = csr_valid ? csr_text_color : text_color_ff;
      blank_color_in = cmd.accept ? text_color_ff : blank_color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff         <= '0;
         col_ff         <= '0;
         ptr_ff         <= '0;
         tab_cnt_ff     <= '0;
         text_color_ff  <= COLOR_RESET;
         blank_color_ff <= COLOR_RESET;
         rsp_valid_ff   <= 1'b0;
         rsp_read_ff    <= 1'b0;
      end else begin
         row_ff         <= row_in;
         col_ff         <= col_in;
         ptr_ff         <= ptr_in;
         tab_cnt_ff     <= tab_cnt_in;
         text_color_ff  <= text_color_in;
         blank_color_ff <= blank_color_in;
         rsp_valid_ff   <= cmd.rsp;
         rsp_read_ff    <= cmd.rsp && cmd.rd && idx_in_range;
      end
   end

   assign status.row_last    = row_last;
   assign status.col_last    = col_last;
   assign status.tab_last    = (tab_cnt_ff == TAB_CNT_W'(1));
   assign status.clear_done  = (ptr_ff == PTR_W'(CELL_COUNT - 1));
   assign status.scroll_done = (ptr_ff == PTR_W'(CELL_COUNT));

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_word  = rsp_read_ff ? rd_data_ff : '0;
   assign rsp_cursor_row = ROW_PORT_W'(row_ff);
   assign rsp_cursor_col = COL_PORT_W'(col_ff);

endmodule

### design/text_console_char_writer_core.sv
// Top level of the text console character writer: controller, datapath and checks.
//
// A command transaction is taken at a rising edge where start is high and busy is
// low; req_op selects put character, clear screen or read cell. Every transaction
// gives one result, shown for exactly one cycle with rsp_valid high: the cell word
// (reads only, zero otherwise) and the cursor after the operation. The receiver
// cannot stall, so the result is simply presented and taken.
// A printable byte that does not scroll, an ignored byte, a newline that does not
// scroll, a read and an unused op give their result the cycle after acceptance,
// and busy stays low, so one transaction per cycle is sustained. A scroll walks the
// single-port-write cell store, copying each row up one and blanking the last row,
// then gives its result. A tab writes its four spaces one per cycle, plus any
// scrolls. A clear writes one cell per cycle over all ROWS*COLUMNS cells, then gives
// its result. After reset the same clearing pass runs with busy high and gives no
// result. The color write channel (csr_) is always ready and may be written at any
// time; a color takes effect for transactions accepted later.
module text_console_char_writer_core import tccw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic [CH_W-1:0]       req_ch,
   input  logic [IDX_W-1:0]      req_cell_index,
   output logic                  rsp_valid,
   output logic [CELL_W-1:0]     rsp_cell_word,
   output logic [ROW_PORT_W-1:0] rsp_cursor_row,
   output logic [COL_PORT_W-1:0] rsp_cursor_col,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COLOR_W-1:0]    csr_text_color
);

   tccw_cmd_type    cmd;
   tccw_status_type status;

   assign csr_ready = 1'b1;

   tccw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .req_ch (req_ch),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   tccw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_ch         (req_ch),
      .req_cell_index (req_cell_index),
      .csr_valid      (csr_valid && csr_ready),
      .csr_text_color (csr_text_color),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_cell_word  (rsp_cell_word),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col)
   );

`ifndef SYNTHESIS
   // A result is only ever presented once the sequencer has returned to accepting.
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result presented while busy");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_READ) |=> rsp_valid)
      else $error("read transaction did not answer in one cycle");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_CLEAR) |=> (busy && !rsp_valid))
      else $error("clear transaction did not start its sweep");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(rsp_cursor_col) < COLUMNS)
      else $error("cursor column out of range");
`endif

endmodule
